[sv/blm_pkg.sv]
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared sizes, curve coefficients, register indexes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package blm_pkg;

	// Filter window and trim depth.
	localparam int WINDOW   = 12;
	localparam int TRIM     = 3;
	// With a window too short to trim, the single entry of middle rank is kept.
	localparam int KEEP     = (WINDOW > 2 * TRIM) ? (WINDOW - 2 * TRIM) : 1;
	localparam int MID_RANK = WINDOW / 2;

	localparam int MV_W   = 13;
	localparam int PCT_W  = 7;
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = MV_W + $clog2(WINDOW);

	localparam int FRAC   = 24;

	// The sum is divided by KEEP as a multiply by the reciprocal rounded up.
	// With four guard bits above the sum width the quotient is exact.
	localparam int AVG_SH     = SUM_W + 4;
	localparam int REC_W      = AVG_SH + 1;
	localparam logic [REC_W-1:0] AVG_RECIP = REC_W'(((1 << AVG_SH) + KEEP - 1) / KEEP);
	localparam int AVG_PROD_W = SUM_W + REC_W;

	// Volts in Q.24: x = mv * 2^24 / 1000 = mv * 16777 + floor(mv * 27 / 125).
	// The second term is mv * 27 * ceil(2^25 / 125), shifted down by 25.
	localparam int XI_W      = MV_W + 15;
	localparam int XF_W      = MV_W + 23;
	localparam logic [14:0] X_INT_MUL  = 15'd16777;
	localparam logic [22:0] X_FRAC_MUL = 23'd7247772;
	localparam int X_FRAC_SH = 25;

	// Horner datapath.
	localparam int X_W    = 27;
	localparam int XL_W   = 14;
	localparam int XH_W   = X_W - XL_W;
	localparam int ACC_W  = 40;
	localparam int PROD_W = ACC_W + X_W + 1;
	localparam int PM_W   = ACC_W + 8;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// Curve breakpoints in millivolts.
	localparam logic [MV_W-1:0] MV_P1_LO = 13'd3450;
	localparam logic [MV_W-1:0] MV_P1_HI = 13'd3590;
	localparam logic [MV_W-1:0] MV_P2_HI = 13'd4049;
	localparam logic [MV_W-1:0] MV_P3_HI = 13'd4200;

	typedef logic [2:0] seg_t;
	localparam seg_t SEG_ZERO = 3'd0;
	localparam seg_t SEG_P1   = 3'd1;
	localparam seg_t SEG_P2   = 3'd2;
	localparam seg_t SEG_P3   = 3'd3;
	localparam seg_t SEG_FULL = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENTS_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LEVEL = 2'd2;

	typedef struct packed {
		logic             events_enable;
		logic [PCT_W-1:0] low_level_percent;
		logic [PCT_W-1:0] critical_level_percent;
	} cfg_t;

	typedef struct packed {
		logic shift_in;
		logic fill_inc;
		logic rank_start;
		logic rank_step;
		logic avg_load;
		logic y_direct;
		logic poly_start;
		logic mul_lo;
		logic mul_hi;
		logic acc_add;
		logic pct_mul;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic ring_full;
		logic rank_last;
		logic seg_poly;
		logic k_last;
		logic out_free;
	} stat_t;

	function automatic logic [1:0] seg_degree(input seg_t seg);
		logic [1:0] d;
		d = (seg == SEG_P2) ? 2'd3 : 2'd2;
		return d;
	endfunction

	// Coefficient k of the polynomial of a segment, Q16.24.
	function automatic logic signed [ACC_W-1:0] coef(input seg_t seg, input logic [1:0] k);
		logic signed [ACC_W-1:0] c;
		c = '0;
		unique case ({seg, k})
			{SEG_P1, 2'd2}: c = 40'sd1479750;
			{SEG_P1, 2'd1}: c = -40'sd7412174;
			{SEG_P1, 2'd0}: c = 40'sd9187203;
			{SEG_P2, 2'd3}: c = -40'sd93126971;
			{SEG_P2, 2'd2}: c = 40'sd1086173741;
			{SEG_P2, 2'd1}: c = -40'sd4187089797;
			{SEG_P2, 2'd0}: c = 40'sd5343543296;
			{SEG_P3, 2'd2}: c = -40'sd48395557;
			{SEG_P3, 2'd1}: c = 40'sd411209564;
			{SEG_P3, 2'd0}: c = -40'sd856460100;
			default:        c = '0;
		endcase
		return c;
	endfunction

endpackage

[sv/blm_sample_if.sv]
// ----------------------------------------------------------------------------
// Battery sample channel
// Valid/ready channel carrying one voltage sample per request.
// ----------------------------------------------------------------------------
interface blm_sample_if;
	import blm_pkg::*;

	logic            valid;
	logic            ready;
	logic [MV_W-1:0] battery_mv;

	modport source(output valid, output battery_mv, input ready);
	modport sink(input valid, input battery_mv, output ready);
endinterface

[sv/blm_result_if.sv]
// ----------------------------------------------------------------------------
// Battery result channel
// Valid/ready channel carrying the mean, the percentage and the events.
// ----------------------------------------------------------------------------
interface blm_result_if;
	import blm_pkg::*;

	logic             valid;
	logic             ready;
	logic [MV_W-1:0]  average_mv;
	logic [PCT_W-1:0] level_percent;
	logic             level_changed;
	logic             low_warning;
	logic             critical_warning;

	modport source(output valid, output average_mv, output level_percent,
		output level_changed, output low_warning, output critical_warning, input ready);
	modport sink(input valid, input average_mv, input level_percent,
		input level_changed, input low_warning, input critical_warning, output ready);
endinterface

[sv/battery_level_monitor_top.sv]
// ----------------------------------------------------------------------------
// Battery level monitor
// Trimmed-mean filter over a window of voltage samples, mapped to a charge
// percentage through a piecewise polynomial, with change, low and critical
// events.
// ----------------------------------------------------------------------------
// Usage: samples arrive on sample_ch, one millivolt value per request. The
// first WINDOW samples only fill the window and produce nothing; every later
// sample produces one request on result_ch with the trimmed mean, the
// percentage and the three event bits.
// The result comes sooner when the mean lies below 3450 mV or above 4200 mV
// than inside that range, where a quadratic or cubic segment is evaluated.
// The path runs through the ranking pass over the window (one entry a
// cycle) and the Horner loop, which steps through the low multiply, high
// multiply and add for each coefficient; both divisions are reciprocal
// multiplies. While the window fills, a sample is taken every cycle.
// One sample is processed at a time; sample_ch.ready is high only while the
// sequencer is idle, so the next sample is taken once it is idle again.
// A finished result waits in the output register, and a new sample is taken
// meanwhile; if the receiver still stalls when the next result is ready, the
// sequencer holds it until the register empties.
// Reset clears the fill count, the previous percentage, the notified flags,
// the output valid flag, and returns the registers to events off, low level
// 20 and critical level 5. Configuration is written through cfg_we,
// cfg_index and cfg_data; an unknown index is ignored.
// ----------------------------------------------------------------------------
module battery_level_monitor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	blm_sample_if.sink                    sample_ch,
	blm_result_if.source                  result_ch,
	input  logic                          cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [blm_pkg::PCT_W-1:0]     cfg_data
);
	import blm_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	// Configuration registers. The user, not the block, ensures these change only when idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.events_enable          <= 1'b0;
			cfg_q.low_level_percent      <= 7'd20;
			cfg_q.critical_level_percent <= 7'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EVENTS_ENABLE:  cfg_q.events_enable          <= cfg_data[0];
				REG_LOW_LEVEL:      cfg_q.low_level_percent      <= cfg_data;
				REG_CRITICAL_LEVEL: cfg_q.critical_level_percent <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// The sequencer issues one command set a cycle; the datapath reports
	// back the window fill, the loop ends, the curve segment and whether the output is free.
	blm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	blm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg              (cfg_q),
		.sample_mv        (sample_ch.battery_mv),
		.out_ready        (result_ch.ready),
		.out_valid        (result_ch.valid),
		.average_mv       (result_ch.average_mv),
		.level_percent    (result_ch.level_percent),
		.level_changed    (result_ch.level_changed),
		.low_warning      (result_ch.low_warning),
		.critical_warning (result_ch.critical_warning)
	);

endmodule

[sv/blm_datapath.sv]
// ----------------------------------------------------------------------------
// Battery level monitor datapath
// Sample shift line, rank-select summing, reciprocal scaling, Horner
// multiplier and the event flags with the output register.
// ----------------------------------------------------------------------------
module blm_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  blm_pkg::cmd_t           cmd,
	output blm_pkg::stat_t          stat,
	input  blm_pkg::cfg_t           cfg,
	input  logic [blm_pkg::MV_W-1:0] sample_mv,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [blm_pkg::MV_W-1:0]  average_mv,
	output logic [blm_pkg::PCT_W-1:0] level_percent,
	output logic                    level_changed,
	output logic                    low_warning,
	output logic                    critical_warning
);
	import blm_pkg::*;

	logic [MV_W-1:0]   ring_q [WINDOW];
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [MV_W-1:0]   avg_q;
	logic [X_W-1:0]    x_q;
	logic [1:0]        k_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PM_W-1:0]   pm_q;
	logic [PCT_W-1:0]  prev_q;
	logic              low_n_q;
	logic              crit_n_q;
	logic              out_valid_q;
	logic [MV_W-1:0]   avg_out_q;
	logic [PCT_W-1:0]  pct_out_q;
	logic              chg_out_q;
	logic              low_out_q;
	logic              crit_out_q;

	logic [MV_W-1:0]  cur;
	logic [IDX_W-1:0] rank;
	logic             keep;
	logic [AVG_PROD_W-1:0] avg_prod;
	logic [XI_W-1:0]       x_int;
	logic [XF_W-1:0]       x_frac;
	seg_t             seg;
	logic signed [ACC_W+XL_W:0]   pl;
	logic signed [ACC_W+XH_W:0]   ph;
	logic signed [PROD_W-1:0]     sh;
	logic                         acc_pos;
	logic [PM_W-FRAC-1:0]         ps;
	logic [PCT_W-1:0]             pct;
	logic                         chg;
	logic                         low_ev;
	logic                         crit_ev;

	// Rank of the selected entry; ties broken by position.
	always_comb begin
		cur  = ring_q[idx_q];
		rank = '0;
		for (int j = 0; j < WINDOW; j++) begin
			if (ring_q[j] < cur || (ring_q[j] == cur && IDX_W'(j) < idx_q)) begin
				rank = rank + 1'b1;
			end
		end
		if (KEEP == 1 && WINDOW <= 2 * TRIM) begin
			keep = (rank == IDX_W'(MID_RANK));
		end else begin
			keep = (rank >= IDX_W'(TRIM)) && (rank < IDX_W'(WINDOW - TRIM));
		end
	end

	// Constant multiplies for the mean and for the volts scaling.
	assign avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);
	assign x_int    = XI_W'(avg_q) * XI_W'(X_INT_MUL);
	assign x_frac   = XF_W'(avg_q) * XF_W'(X_FRAC_MUL);

	always_comb begin
		if (avg_q < MV_P1_LO)       seg = SEG_ZERO;
		else if (avg_q <= MV_P1_HI) seg = SEG_P1;
		else if (avg_q <= MV_P2_HI) seg = SEG_P2;
		else if (avg_q <= MV_P3_HI) seg = SEG_P3;
		else                        seg = SEG_FULL;
	end

	assign pl = acc_q * $signed({1'b0, x_q[XL_W-1:0]});
	assign ph = acc_q * $signed({1'b0, x_q[X_W-1:XL_W]});
	assign sh = prod_q >>> FRAC;

	always_comb begin
		acc_pos = !acc_q[ACC_W-1] && (acc_q != '0);
		ps      = pm_q[PM_W-1:FRAC];
		if (!acc_pos) begin
			pct = '0;
		end else if (ps > (PM_W-FRAC)'(PCT_MAX)) begin
			pct = PCT_MAX;
		end else begin
			pct = ps[PCT_W-1:0];
		end
		chg     = cfg.events_enable && (pct != prev_q);
		low_ev  = cfg.events_enable && (pct <= cfg.low_level_percent) && !low_n_q;
		crit_ev = cfg.events_enable && (pct <= cfg.critical_level_percent) && !crit_n_q;
	end

	always_comb begin
		stat.ring_full = (fill_q == CNT_W'(WINDOW));
		stat.rank_last = (idx_q == IDX_W'(WINDOW - 1));
		stat.seg_poly  = (seg == SEG_P1) || (seg == SEG_P2) || (seg == SEG_P3);
		stat.k_last    = (k_q == 2'd1);
		stat.out_free  = !out_valid_q;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			ring_q[0] <= sample_mv;
			for (int i = 1; i < WINDOW; i++) begin
				ring_q[i] <= ring_q[i-1];
			end
		end
		if (cmd.rank_start) begin
			sum_q <= '0;
		end else if (cmd.rank_step && keep) begin
			sum_q <= sum_q + SUM_W'(cur);
		end
		if (cmd.avg_load) begin
			avg_q <= avg_prod[AVG_SH +: MV_W];
		end
		if (cmd.y_direct) begin
			acc_q <= (seg == SEG_FULL) ? (ACC_W'(1) <<< FRAC) : '0;
		end else if (cmd.poly_start) begin
			x_q   <= X_W'(x_int + XI_W'(x_frac >> X_FRAC_SH));
			acc_q <= coef(seg, seg_degree(seg));
			k_q   <= seg_degree(seg);
		end else if (cmd.acc_add) begin
			acc_q <= ACC_W'(sh) + coef(seg, k_q - 2'd1);
			k_q   <= k_q - 2'd1;
		end
		if (cmd.mul_lo) begin
			prod_q <= PROD_W'(pl);
		end else if (cmd.mul_hi) begin
			prod_q <= prod_q + (PROD_W'(ph) <<< XL_W);
		end
		if (cmd.pct_mul) begin
			pm_q <= PM_W'(acc_q * $signed(8'd100));
		end
		if (cmd.result_load) begin
			avg_out_q  <= avg_q;
			pct_out_q  <= pct;
			chg_out_q  <= chg;
			low_out_q  <= low_ev;
			crit_out_q <= crit_ev;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			prev_q      <= '0;
			low_n_q     <= 1'b0;
			crit_n_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.rank_start) begin
				idx_q <= '0;
			end else if (cmd.rank_step) begin
				idx_q <= stat.rank_last ? '0 : idx_q + 1'b1;
			end
			if (cmd.result_load) begin
				prev_q      <= pct;
				out_valid_q <= 1'b1;
				if (pct > cfg.low_level_percent) begin
					low_n_q <= 1'b0;
				end else if (low_ev) begin
					low_n_q <= 1'b1;
				end
				if (pct > cfg.critical_level_percent) begin
					crit_n_q <= 1'b0;
				end else if (crit_ev) begin
					crit_n_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign average_mv       = avg_out_q;
	assign level_percent    = pct_out_q;
	assign level_changed    = chg_out_q;
	assign low_warning      = low_out_q;
	assign critical_warning = crit_out_q;

endmodule

[sv/blm_ctrl.sv]
// ----------------------------------------------------------------------------
// Battery level monitor controller
// Sequences one sample through ranking, scaling, curve and event stages.
// ----------------------------------------------------------------------------
module blm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  blm_pkg::stat_t stat,
	output blm_pkg::cmd_t  cmd
);
	import blm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RANK = 4'd1;
	localparam logic [3:0] S_AVG  = 4'd2;
	localparam logic [3:0] S_SEL  = 4'd3;
	localparam logic [3:0] S_MLO  = 4'd4;
	localparam logic [3:0] S_MHI  = 4'd5;
	localparam logic [3:0] S_ADD  = 4'd6;
	localparam logic [3:0] S_PCT  = 4'd7;
	localparam logic [3:0] S_EVT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.shift_in = 1'b1;
					if (stat.ring_full) begin
						cmd.rank_start = 1'b1;
						state_d        = S_RANK;
					end else begin
						cmd.fill_inc = 1'b1;
					end
				end
			end
			S_RANK: begin
				cmd.rank_step = 1'b1;
				if (stat.rank_last) state_d = S_AVG;
			end
			S_AVG: begin
				cmd.avg_load = 1'b1;
				state_d      = S_SEL;
			end
			S_SEL: begin
				if (stat.seg_poly) begin
					cmd.poly_start = 1'b1;
					state_d        = S_MLO;
				end else begin
					cmd.y_direct = 1'b1;
					state_d      = S_PCT;
				end
			end
			S_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MHI;
			end
			S_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_ADD;
			end
			S_ADD: begin
				cmd.acc_add = 1'b1;
				state_d     = stat.k_last ? S_PCT : S_MLO;
			end
			S_PCT: begin
				cmd.pct_mul = 1'b1;
				state_d     = S_EVT;
			end
			S_EVT: begin
				if (stat.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
